### rtl/core/cde_pkg.sv
// Shared constants, codes and types of the canvas draw engine.
// No dependencies; the engine core and the ellipse unit import this package.
package cde_pkg;

  localparam int ROWS   = 32;
  localparam int COLS   = 64;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int CELLS  = ROWS * COLS;
  localparam int CELL_W = $clog2(CELLS);

  // largest square side and longest line that can fit on the canvas
  localparam int SQ_MAX     = (ROWS < COLS) ? ROWS : COLS;
  localparam int LN_MAX     = (ROWS > COLS) ? ROWS : COLS;
  localparam int SNAP_DEPTH = (SQ_MAX * SQ_MAX > LN_MAX) ? SQ_MAX * SQ_MAX : LN_MAX;
  localparam int SNAP_W     = $clog2(SNAP_DEPTH);

  localparam logic [2:0] WHITE = 3'd4;

  // ellipse multiplier: operands and product
  localparam int MUL_W = 25;
  localparam int PRD_W = 2 * MUL_W;

  localparam logic [2:0] CMD_ELLIPSE = 3'd0;
  localparam logic [2:0] CMD_LINE    = 3'd1;
  localparam logic [2:0] CMD_SQUARE  = 3'd2;
  localparam logic [2:0] CMD_SHADE   = 3'd3;
  localparam logic [2:0] CMD_COPY    = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;

  localparam logic [8:0] DEG_0   = 9'd0;
  localparam logic [8:0] DEG_45  = 9'd45;
  localparam logic [8:0] DEG_90  = 9'd90;
  localparam logic [8:0] DEG_135 = 9'd135;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_225 = 9'd225;
  localparam logic [8:0] DEG_270 = 9'd270;
  localparam logic [8:0] DEG_315 = 9'd315;
  localparam logic [9:0] DEG_360 = 10'd360;
  localparam logic [9:0] DEG_720 = 10'd720;

  typedef logic signed [10:0] crd_t;
  typedef logic signed [1:0]  stp_t;

  typedef enum logic [3:0] {
    DIR_0, DIR_45, DIR_90, DIR_135, DIR_180, DIR_225, DIR_270, DIR_315, DIR_NONE
  } dir_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_DRAW, ST_CP_RD, ST_CP_SW, ST_PS_RD, ST_PS_WR,
    ST_PIX, ST_EL_GO, ST_EL_WAIT, ST_EL_WR, ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    PR_CTR, PR_UP, PR_RIGHT, PR_DOWN, PR_LEFT
  } probe_t;

  typedef struct packed {
    crd_t r0;
    crd_t c0;
    stp_t dr;
    stp_t dc;
    logic ok;
  } geo_t;

  typedef struct packed {
    logic start;
    crd_t pt_r;
    crd_t pt_c;
  } ell_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } ell_rsp_t;

endpackage

### rtl/core/cde_if.sv
// Handshake channels of the canvas draw engine: command words in, result words out.
// Standalone; no package needed.
interface cde_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic signed [7:0] row_a;
  logic signed [7:0] col_a;
  logic signed [7:0] length;
  logic [9:0]        direction;
  logic signed [7:0] row_b;
  logic signed [7:0] col_b;
  logic [11:0]       focal_len;
  logic              hollow;
  logic signed [3:0] shade_delta;

  modport source (output valid, cmd, row_a, col_a, length, direction, row_b, col_b,
                  focal_len, hollow, shade_delta, input ready);
  modport sink   (input valid, cmd, row_a, col_a, length, direction, row_b, col_b,
                  focal_len, hollow, shade_delta, output ready);
endinterface

interface cde_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] pixel_value;
  logic       in_canvas;
  logic [2:0] current_shade;

  modport source (output valid, pixel_value, in_canvas, current_shade, input ready);
  modport sink   (input valid, pixel_value, in_canvas, current_shade, output ready);
endinterface

### rtl/core/canvas_draw_engine_core.sv
// Canvas draw engine: command words in, one result word out per command.
// Ellipse commands run one membership test per canvas pixel, up to five when hollow.
// Shapes that do not fit on the canvas are skipped, and a result word is still issued.
// One command at a time: the next word is taken only after the result word is issued.
// Reset: synchronous, active low; then a clearing pass paints all ROWS*COLS pixels
// white before the first command word is taken. Shade resets to black.
module canvas_draw_engine_core (
  input  logic clk,
  input  logic rst_n,
  cde_in_if.sink    in_ch,
  cde_out_if.source out_ch
);
  import cde_pkg::*;

  // ---- helpers --------------------------------------------------------------
  function automatic logic onc(input crd_t r, input crd_t c);
    return (r >= 0) && (r < crd_t'(ROWS)) && (c >= 0) && (c < crd_t'(COLS));
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(input crd_t r, input crd_t c);
    return CELL_W'(r[ROW_W-1:0]) * CELL_W'(COLS) + CELL_W'(c[COL_W-1:0]);
  endfunction

  function automatic logic is_axis(input dir_t d);
    return (d == DIR_0) || (d == DIR_90) || (d == DIR_180) || (d == DIR_270);
  endfunction

  // start point and unit step of a line
  function automatic geo_t line_org(input dir_t d, input crd_t r, input crd_t c,
                                    input crd_t s);
    geo_t g;
    g.r0 = r;  g.c0 = c;  g.dr = 2'sd1;  g.dc = 2'sd0;  g.ok = 1'b1;
    case (d)
      DIR_0:   g.r0 = r - s;
      DIR_90:  begin g.dr = 2'sd0; g.dc = 2'sd1; end
      DIR_180: ;
      DIR_270: begin g.c0 = c - s; g.dr = 2'sd0; g.dc = 2'sd1; end
      DIR_45:  begin g.r0 = r - s; g.c0 = c + s; g.dc = -2'sd1; end
      DIR_135: g.dc = 2'sd1;
      DIR_225: g.dc = -2'sd1;
      DIR_315: begin g.r0 = r - s; g.c0 = c - s; g.dc = 2'sd1; end
      default: g.ok = 1'b0;
    endcase
    return g;
  endfunction

  function automatic logic line_fits(input geo_t g, input crd_t s);
    crd_t er, ec;
    er = (g.dr == 2'sd1) ? g.r0 + s : g.r0;
    ec = (g.dc == 2'sd1) ? g.c0 + s : ((g.dc == -2'sd1) ? g.c0 - s : g.c0);
    return onc(g.r0, g.c0) && onc(er, ec);
  endfunction

  // top-left corner of a square; inner step runs along the row
  function automatic geo_t sq_org(input dir_t d, input crd_t r, input crd_t c,
                                  input crd_t s);
    geo_t g;
    g.r0 = r;  g.c0 = c;  g.dr = 2'sd0;  g.dc = 2'sd1;  g.ok = 1'b1;
    case (d)
      DIR_45:  g.r0 = r - s;
      DIR_135: ;
      DIR_225: g.c0 = c - s;
      DIR_315: begin g.r0 = r - s; g.c0 = c - s; end
      default: g.ok = 1'b0;
    endcase
    return g;
  endfunction

  function automatic logic sq_fits(input geo_t g, input crd_t s);
    return onc(g.r0, g.c0) && onc(g.r0 + s, g.c0 + s);
  endfunction

  // ---- registers --------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [CELL_W-1:0] clr_cnt_r;
  logic [2:0]        shade_r;

  // command word as taken
  logic [2:0]        cmd_r;
  logic signed [7:0] ra_r, ca_r, rb_r, cb_r;
  logic [11:0]       fl_r;
  logic              hol_r;
  logic signed [3:0] delta_r;
  logic [7:0]        len_r;
  dir_t              dir_r;

  // walker over a line or a square
  crd_t              cur_r_r, cur_c_r, row_r_r, row_c_r, tgt_r_r, tgt_c_r;
  stp_t              dr_r, dc_r;
  logic [6:0]        j_r, i_r, lastcol_r, lastrow_r;
  logic [SNAP_W-1:0] k_r;

  // ellipse raster scan
  logic [ROW_W-1:0]  er_r;
  logic [COL_W-1:0]  ec_r;
  probe_t            q_r;

  // result
  logic              px_on_r;
  logic [2:0]        res_pv_r;
  logic              res_inc_r;
  logic              out_valid_r;
  logic [2:0]        out_pv_r, out_cs_r;
  logic              out_inc_r;

  // memories
  logic [2:0]        pix_mem [CELLS];
  logic [2:0]        snap_mem [SNAP_DEPTH];
  logic [2:0]        pix_q, snap_q;
  logic [CELL_W-1:0] pix_addr;
  logic              pix_we;
  logic [2:0]        pix_wd;

  // ---- input decode: angle mod 360, sign flip ---------------------------------
  logic [9:0] dmod;
  logic [8:0] dflip;
  logic       len_neg;
  dir_t       dir_in;

  assign len_neg = in_ch.length[7];

  always_comb begin
    if (in_ch.direction >= DEG_720)      dmod = in_ch.direction - DEG_720;
    else if (in_ch.direction >= DEG_360) dmod = in_ch.direction - DEG_360;
    else                                 dmod = in_ch.direction;
    if (!len_neg)                        dflip = dmod[8:0];
    else if (dmod[8:0] < DEG_180)        dflip = dmod[8:0] + DEG_180;
    else                                 dflip = dmod[8:0] - DEG_180;
    case (dflip)
      DEG_0:   dir_in = DIR_0;
      DEG_45:  dir_in = DIR_45;
      DEG_90:  dir_in = DIR_90;
      DEG_135: dir_in = DIR_135;
      DEG_180: dir_in = DIR_180;
      DEG_225: dir_in = DIR_225;
      DEG_270: dir_in = DIR_270;
      DEG_315: dir_in = DIR_315;
      default: dir_in = DIR_NONE;
    endcase
  end

  // ---- geometry of the taken command ------------------------------------------
  crd_t       s_crd;
  logic       use_line, src_ok, tgt_ok;
  geo_t       src_g, tgt_g;
  logic [4:0] shade_sum;

  assign s_crd    = crd_t'({3'b000, len_r}) - crd_t'(1);
  assign use_line = (cmd_r == CMD_LINE) || is_axis(dir_r);

  always_comb begin
    if (use_line) begin
      src_g  = line_org(dir_r, crd_t'(ra_r), crd_t'(ca_r), s_crd);
      tgt_g  = line_org(dir_r, crd_t'(rb_r), crd_t'(cb_r), s_crd);
      src_ok = src_g.ok && line_fits(src_g, s_crd);
      tgt_ok = tgt_g.ok && line_fits(tgt_g, s_crd);
    end else begin
      src_g  = sq_org(dir_r, crd_t'(ra_r), crd_t'(ca_r), s_crd);
      tgt_g  = sq_org(dir_r, crd_t'(rb_r), crd_t'(cb_r), s_crd);
      src_ok = src_g.ok && sq_fits(src_g, s_crd);
      tgt_ok = tgt_g.ok && sq_fits(tgt_g, s_crd);
    end
  end

  assign shade_sum = {2'b00, shade_r} + 5'(delta_r);

  // ---- walker -------------------------------------------------------------------
  logic walk_eol, walk_end, adv, reload;

  assign walk_eol = (j_r == lastcol_r);
  assign walk_end = walk_eol && (i_r == lastrow_r);
  assign adv      = (state_r == ST_DRAW) || (state_r == ST_PS_WR) ||
                    ((state_r == ST_CP_SW) && !walk_end);
  assign reload   = (state_r == ST_CP_SW) && walk_end;

  // ---- ellipse unit ---------------------------------------------------------------
  ell_req_t el_req;
  ell_rsp_t el_rsp;
  crd_t     pt_r, pt_c;
  logic     el_draw, el_more, el_last, el_next;

  always_comb begin
    pt_r = crd_t'(er_r);
    pt_c = crd_t'(ec_r);
    unique case (q_r)
      PR_UP:    pt_r = crd_t'(er_r) - crd_t'(1);
      PR_RIGHT: pt_c = crd_t'(ec_r) + crd_t'(1);
      PR_DOWN:  pt_r = crd_t'(er_r) + crd_t'(1);
      PR_LEFT:  pt_c = crd_t'(ec_r) - crd_t'(1);
      default:  ;
    endcase
  end

  assign el_req.start = (state_r == ST_EL_GO);
  assign el_req.pt_r  = pt_r;
  assign el_req.pt_c  = pt_c;

  cde_ell u_ell (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (el_req),
    .f1_r (ra_r),
    .f1_c (ca_r),
    .f2_r (rb_r),
    .f2_c (cb_r),
    .fl   (fl_r),
    .rsp  (el_rsp)
  );

  // centre inside: fill draws, outline looks at neighbours; any neighbour outside draws
  assign el_draw = (state_r == ST_EL_WAIT) && el_rsp.done &&
                   (((q_r == PR_CTR) && el_rsp.hit && !hol_r) ||
                    ((q_r != PR_CTR) && !el_rsp.hit));
  assign el_more = (state_r == ST_EL_WAIT) && el_rsp.done && el_rsp.hit &&
                   (((q_r == PR_CTR) && hol_r) ||
                    ((q_r != PR_CTR) && (q_r != PR_LEFT)));
  assign el_next = (state_r == ST_EL_WR) ||
                   ((state_r == ST_EL_WAIT) && el_rsp.done && !el_draw && !el_more);
  assign el_last = (er_r == ROW_W'(ROWS - 1)) && (ec_r == COL_W'(COLS - 1));

  // ---- state machine ----------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == CELL_W'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_SETUP;
      ST_SETUP: begin
        case (cmd_r)
          CMD_ELLIPSE: state_nxt = ST_EL_GO;
          CMD_LINE,
          CMD_SQUARE:  state_nxt = (src_ok && len_r != 8'd0) ? ST_DRAW : ST_RESP;
          CMD_COPY:    state_nxt = (src_ok && tgt_ok && len_r != 8'd0) ? ST_CP_RD : ST_RESP;
          CMD_READ:    state_nxt = ST_PIX;
          default:     state_nxt = ST_RESP;
        endcase
      end
      ST_DRAW:    if (walk_end) state_nxt = ST_RESP;
      ST_CP_RD:   state_nxt = ST_CP_SW;
      ST_CP_SW:   state_nxt = walk_end ? ST_PS_RD : ST_CP_RD;
      ST_PS_RD:   state_nxt = ST_PS_WR;
      ST_PS_WR:   state_nxt = walk_end ? ST_RESP : ST_PS_RD;
      ST_PIX:     state_nxt = ST_RESP;
      ST_EL_GO:   state_nxt = ST_EL_WAIT;
      ST_EL_WAIT: begin
        if (el_draw)      state_nxt = ST_EL_WR;
        else if (el_more) state_nxt = ST_EL_GO;
        else if (el_next) state_nxt = el_last ? ST_RESP : ST_EL_GO;
      end
      ST_EL_WR:   state_nxt = el_last ? ST_RESP : ST_EL_GO;
      ST_RESP:    if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // ---- control registers (reset) --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      shade_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + CELL_W'(1);
      // a shade change outside 0..4 is dropped
      if (state_r == ST_SETUP && cmd_r == CMD_SHADE && !shade_sum[4] &&
          shade_sum[3:0] <= 4'(WHITE))
        shade_r <= shade_sum[2:0];
      if (state_r == ST_RESP && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready)                                    out_valid_r <= 1'b0;
    end
  end

  // ---- datapath registers -------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      cmd_r   <= in_ch.cmd;
      ra_r    <= in_ch.row_a;
      ca_r    <= in_ch.col_a;
      rb_r    <= in_ch.row_b;
      cb_r    <= in_ch.col_b;
      fl_r    <= in_ch.focal_len;
      hol_r   <= in_ch.hollow;
      delta_r <= in_ch.shade_delta;
      len_r   <= len_neg ? 8'(-in_ch.length) : 8'(in_ch.length);
      dir_r   <= dir_in;
    end

    if (state_r == ST_SETUP) begin
      cur_r_r   <= src_g.r0;
      cur_c_r   <= src_g.c0;
      row_r_r   <= src_g.r0;
      row_c_r   <= src_g.c0;
      tgt_r_r   <= tgt_g.r0;
      tgt_c_r   <= tgt_g.c0;
      dr_r      <= src_g.dr;
      dc_r      <= src_g.dc;
      j_r       <= '0;
      i_r       <= '0;
      k_r       <= '0;
      lastcol_r <= 7'(len_r - 8'd1);
      lastrow_r <= use_line ? 7'd0 : 7'(len_r - 8'd1);
      er_r      <= '0;
      ec_r      <= '0;
      q_r       <= PR_CTR;
      px_on_r   <= onc(crd_t'(ra_r), crd_t'(ca_r));
      res_pv_r  <= '0;
      res_inc_r <= 1'b0;
    end

    if (adv) begin
      k_r <= k_r + SNAP_W'(1);
      if (walk_eol) begin
        j_r     <= '0;
        i_r     <= i_r + 7'd1;
        row_r_r <= row_r_r + crd_t'(1);
        cur_r_r <= row_r_r + crd_t'(1);
        cur_c_r <= row_c_r;
      end else begin
        j_r     <= j_r + 7'd1;
        cur_r_r <= cur_r_r + crd_t'(dr_r);
        cur_c_r <= cur_c_r + crd_t'(dc_r);
      end
    end else if (reload) begin
      // snapshot taken: restart the walk at the paste target
      k_r     <= '0;
      j_r     <= '0;
      i_r     <= '0;
      cur_r_r <= tgt_r_r;
      cur_c_r <= tgt_c_r;
      row_r_r <= tgt_r_r;
      row_c_r <= tgt_c_r;
    end

    if (el_more) q_r <= probe_t'(q_r + 3'd1);
    if (el_next) begin
      q_r <= PR_CTR;
      if (ec_r == COL_W'(COLS - 1)) begin
        ec_r <= '0;
        er_r <= er_r + ROW_W'(1);
      end else begin
        ec_r <= ec_r + COL_W'(1);
      end
    end

    if (state_r == ST_PIX) begin
      res_pv_r  <= px_on_r ? pix_q : 3'd0;
      res_inc_r <= px_on_r;
    end

    if (state_r == ST_RESP && (!out_valid_r || out_ch.ready)) begin
      out_pv_r  <= res_pv_r;
      out_inc_r <= res_inc_r;
      out_cs_r  <= shade_r;
    end
  end

  // ---- pixel RAM: one port, registered read ---------------------------------------------
  always_comb begin
    pix_addr = cell_addr(cur_r_r, cur_c_r);
    pix_we   = 1'b0;
    pix_wd   = shade_r;
    unique case (state_r)
      ST_CLEAR: begin pix_addr = clr_cnt_r; pix_we = 1'b1; pix_wd = WHITE; end
      ST_SETUP: pix_addr = cell_addr(crd_t'(ra_r), crd_t'(ca_r));
      ST_DRAW:  pix_we = 1'b1;
      ST_PS_WR: begin pix_we = 1'b1; pix_wd = snap_q; end
      ST_EL_WR: begin
        pix_addr = cell_addr(crd_t'(er_r), crd_t'(ec_r));
        pix_we   = 1'b1;
      end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_addr] <= pix_wd;
    pix_q <= pix_mem[pix_addr];
  end

  // ---- snapshot RAM ----------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == ST_CP_SW) snap_mem[k_r] <= pix_q;
    snap_q <= snap_mem[k_r];
  end

  // ---- ports -----------------------------------------------------------------------------
  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_value   = out_pv_r;
  assign out_ch.in_canvas     = out_inc_r;
  assign out_ch.current_shade = out_cs_r;

endmodule

### rtl/core/cde_ell.sv
// Ellipse membership unit: one shared multiplier, stepped from EL_SQ_A1 through EL_CMP.
// Depends on cde_pkg.
module cde_ell (
  input  logic              clk,
  input  logic              rst_n,
  input  cde_pkg::ell_req_t req,
  input  logic signed [7:0] f1_r,
  input  logic signed [7:0] f1_c,
  input  logic signed [7:0] f2_r,
  input  logic signed [7:0] f2_c,
  input  logic [11:0]       fl,
  output cde_pkg::ell_rsp_t rsp
);
  import cde_pkg::*;

  typedef enum logic [2:0] {
    EL_SQ_A1, EL_SQ_B1, EL_SQ_A2, EL_SQ_B2, EL_SQ_FL, EL_AB, EL_DD, EL_CMP
  } step_t;

  function automatic logic [8:0] mag(input crd_t v);
    crd_t n;
    n = -v;
    return v[10] ? n[8:0] : v[8:0];
  endfunction

  logic               busy_r;
  step_t              st_r;
  logic [8:0]         a1_r, b1_r, a2_r, b2_r;
  logic [11:0]        fl_r;
  logic [PRD_W-1:0]   p_r, ab_r;
  logic [18:0]        s1_r, s2_r;
  logic [MUL_W-1:0]   d_r;
  logic               over_r;

  logic [MUL_W-1:0]   op_x, op_y, big_a, big_b;
  logic [PRD_W-1:0]   prod;
  logic [MUL_W:0]     sum_ab, c2_x;

  assign big_a  = {s1_r, 6'b0};
  assign big_b  = {s2_r, 6'b0};
  assign sum_ab = {1'b0, big_a} + {1'b0, big_b};
  assign c2_x   = (MUL_W + 1)'(p_r[23:0]);

  always_comb begin
    unique case (st_r)
      EL_SQ_A1: begin op_x = MUL_W'(a1_r); op_y = MUL_W'(a1_r); end
      EL_SQ_B1: begin op_x = MUL_W'(b1_r); op_y = MUL_W'(b1_r); end
      EL_SQ_A2: begin op_x = MUL_W'(a2_r); op_y = MUL_W'(a2_r); end
      EL_SQ_B2: begin op_x = MUL_W'(b2_r); op_y = MUL_W'(b2_r); end
      EL_SQ_FL: begin op_x = MUL_W'(fl_r); op_y = MUL_W'(fl_r); end
      EL_AB:    begin op_x = big_a;        op_y = big_b;        end
      EL_DD:    begin op_x = d_r;          op_y = d_r;          end
      default:  begin op_x = '0;           op_y = '0;           end
    endcase
  end

  assign prod = op_x * op_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      st_r   <= EL_SQ_A1;
    end else if (req.start) begin
      busy_r <= 1'b1;
      st_r   <= EL_SQ_A1;
    end else if (busy_r) begin
      st_r <= step_t'(st_r + 3'd1);
      if (st_r == EL_CMP) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a1_r <= mag(req.pt_r - crd_t'(f1_r));
      b1_r <= mag(req.pt_c - crd_t'(f1_c));
      a2_r <= mag(req.pt_r - crd_t'(f2_r));
      b2_r <= mag(req.pt_c - crd_t'(f2_c));
      fl_r <= fl;
    end else if (busy_r) begin
      p_r <= prod;
      unique case (st_r)
        EL_SQ_B1: s1_r <= p_r[18:0];
        EL_SQ_A2: s1_r <= s1_r + p_r[18:0];
        EL_SQ_B2: s2_r <= p_r[18:0];
        EL_SQ_FL: s2_r <= s2_r + p_r[18:0];
        EL_AB: begin
          over_r <= sum_ab > c2_x;
          d_r    <= MUL_W'(c2_x - sum_ab);
        end
        EL_DD:   ab_r <= p_r;
        default: ;
      endcase
    end
  end

  assign rsp.done = busy_r && (st_r == EL_CMP);
  assign rsp.hit  = !over_r && ({ab_r, 2'b00} <= {2'b00, p_r});

endmodule
